[rtl/aodv_rt_pkg.sv]
// Package: shared types, constants and command codes of the route table engine.
package aodv_rt_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_RESULTS  = 32;
    localparam int BREAK_FACTOR = 10;
    localparam int APB_ADDR_W   = 4;
    localparam int TERM_W       = 20;

    // Command codes
    localparam logic [2:0] CMD_FWD    = 3'd0;
    localparam logic [2:0] CMD_REV    = 3'd1;
    localparam logic [2:0] CMD_NBR    = 3'd2;
    localparam logic [2:0] CMD_BREAK  = 3'd3;
    localparam logic [2:0] CMD_ACTIVE = 3'd4;
    localparam logic [2:0] CMD_VALID  = 3'd5;

    // Register indexes
    localparam logic [1:0] REG_PTT = 2'd0;
    localparam logic [1:0] REG_NTT = 2'd1;
    localparam logic [1:0] REG_ART = 2'd2;

    // Route status codes
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_BROKEN = 2'd2;

    localparam logic [7:0] HOP_INF       = 8'd255;
    localparam logic [7:0] NEIGHBOR_HOPS = 8'd1;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] next;
        logic [7:0]  hops;
        logic [7:0]  prev_hops;
        logic [31:0] seq;
        logic [31:0] expiry;
        logic [1:0]  status;
    } entry_t;

    typedef struct packed {
        logic [31:0] route_addr;
        logic        found;
        logic [31:0] route_next_hop;
        logic [7:0]  route_hops;
        logic [31:0] route_seq;
        logic        kernel_del;
        logic        kernel_add;
        logic        table_full;
        logic        last;
    } result_t;

    // Operands of the shared lifetime adder: now + add - sub, clamped
    typedef struct packed {
        logic [31:0]       now;
        logic [31:0]       add;
        logic [TERM_W-1:0] sub;
    } life_op_t;

endpackage

[rtl/aodv_rt_if.sv]
// Interfaces: command request channel and route result channel.
interface aodv_rt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] dest_addr;
    logic [31:0] next_hop;
    logic [7:0]  msg_hop_count;
    logic [31:0] seq_num;
    logic [31:0] lifetime;
    logic [31:0] now;

    modport source (output valid, cmd, dest_addr, next_hop, msg_hop_count, seq_num,
                    lifetime, now, input ready);
    modport sink   (input valid, cmd, dest_addr, next_hop, msg_hop_count, seq_num,
                    lifetime, now, output ready);
endinterface

interface aodv_rt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] route_addr;
    logic        found;
    logic [31:0] route_next_hop;
    logic [7:0]  route_hops;
    logic [31:0] route_seq;
    logic        kernel_del;
    logic        kernel_add;
    logic        table_full;
    logic        last;

    modport source (output valid, route_addr, found, route_next_hop, route_hops, route_seq,
                    kernel_del, kernel_add, table_full, last, input ready);
    modport sink   (input valid, route_addr, found, route_next_hop, route_hops, route_seq,
                    kernel_del, kernel_add, table_full, last, output ready);
endinterface

[rtl/aodv_route_table_engine.sv]
// Top level: route table storage, scan sequencer, APB registers and result register.
//
// Route table engine with 32 entries held in registers and visited one entry per
// cycle by a small sequencer while no result waits to be taken. Each command
// scans the whole table once to find the destination and the first free entry,
// then passes S_CALC to form the lifetime term and S_APPLY for the update; the
// block stays busy until its result is taken. A link break with dependent routes
// walks the table a second time and marks each dependent active route broken.
// All lifetime sums go through one shared saturating adder. Codes 6 and 7 are
// taken and dropped. The registers sit at APB byte offsets 0, 4 and 8; they must
// be written by the user only while the block is idle; it does not enforce this.
module aodv_route_table_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    aodv_rt_req_if.sink                           req,
    aodv_rt_rsp_if.source                         rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [aodv_rt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import aodv_rt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_WOUT  = 3'd6;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

    // Configuration registers
    logic [15:0] ptt_reg;
    logic [9:0]  ntt_reg;
    logic [15:0] art_reg;

    // Table storage
    entry_t                 entry_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used_reg, used_next;

    // Sequencer state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]  dep_reg, dep_next;
    logic [CNT_W-1:0]  sent_reg, sent_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [TERM_W-1:0] term_reg, term_next;

    // Latched command
    logic [2:0]  cmd_reg;
    logic [31:0] dest_reg, nh_reg, seq_reg, life_reg, now_reg;
    logic [7:0]  msgh_reg;

    // Result register
    logic    rsp_valid_reg, rsp_valid_next;
    result_t res_reg, res_next;

    // Table write port
    logic   wr_en;
    entry_t wr_data;

    entry_t           rd;
    logic             match, dependent, rd_used, idx_end;
    logic [7:0]       hops_in;
    logic [17:0]      hop_prod;
    life_op_t         life_op;
    logic [31:0]      life_val;
    logic [31:0]      seq_diff, seq_back;
    logic             newer, accept;
    logic [CNT_W-1:0] tot_raw;

    function automatic result_t entry_result(entry_t e, logic kd, logic ka, logic lst);
        result_t r;
        r.route_addr     = e.dest;
        r.found          = 1'b1;
        r.route_next_hop = e.next;
        r.route_hops     = e.hops;
        r.route_seq      = e.seq;
        r.kernel_del     = kd;
        r.kernel_add     = ka;
        r.table_full     = 1'b0;
        r.last           = lst;
        return r;
    endfunction

    function automatic result_t blank_result(logic [31:0] addr, logic full, logic lst);
        result_t r;
        r            = '0;
        r.route_addr = addr;
        r.table_full = full;
        r.last       = lst;
        return r;
    endfunction

    aodv_rt_life u_life (
        .op   (life_op),
        .life (life_val)
    );

    // Read the entry under the sequencer index
    assign rd        = entry_mem[idx_reg];
    assign rd_used   = used_reg[idx_reg];
    assign match     = rd_used && (rd.dest == dest_reg);
    assign dependent = rd_used && (rd.dest != dest_reg) && (rd.next == dest_reg)
                       && (rd.status == ST_ACTIVE);
    assign idx_end   = (idx_reg == IDX_LAST);
    assign hops_in   = (msgh_reg == HOP_INF) ? HOP_INF : msgh_reg + 8'd1;
    assign hop_prod  = 18'(hops_in) * 18'(ntt_reg);
    assign seq_diff  = seq_reg - rd.seq;
    assign seq_back  = rd.seq - seq_reg;
    assign newer     = (seq_diff != 32'd0) && !seq_diff[31];
    assign accept    = newer || ((seq_diff == 32'd0) && (hops_in < rd.hops));
    assign tot_raw   = CNT_W'(hit_reg) + dep_reg;

    // Select the lifetime adder operands
    always_comb
    begin
        life_op.now = now_reg;
        life_op.add = life_reg;
        life_op.sub = '0;
        if (state_reg == S_WALK)
            life_op.add = {16'd0, art_reg};
        else
        begin
            case (cmd_reg)
                CMD_REV:
                begin
                    life_op.add = {16'd0, ptt_reg};
                    life_op.sub = term_reg;
                end
                CMD_BREAK: life_op.add = {{(32-TERM_W){1'b0}}, term_reg};
                default:   life_op.add = life_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        dep_next       = dep_reg;
        sent_next      = sent_reg;
        total_next     = total_reg;
        term_next      = term_reg;
        rsp_valid_next = rsp_valid_reg;
        res_next       = res_reg;
        used_next      = used_reg;
        wr_en          = 1'b0;
        wr_data        = rd;

        case (state_reg)
            S_IDLE:
            begin
                // Take a command; drop unknown codes
                if (req.valid && (req.cmd <= CMD_VALID))
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    dep_next   = '0;
                end
            end
            S_SCAN:
            begin
                // Find the destination, the first free entry and dependent routes
                if (match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!rd_used && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (dependent)
                    dep_next = dep_reg + CNT_W'(1);
                if (idx_end)
                    state_next = S_CALC;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_CALC:
            begin
                // Point at the target entry and form the lifetime term
                idx_next   = hit_reg ? hit_idx_reg : free_idx_reg;
                term_next  = (cmd_reg == CMD_REV) ? {1'b0, hop_prod, 1'b0}
                                                  : TERM_W'(art_reg) * TERM_W'(BREAK_FACTOR);
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next     = S_OUT;
                rsp_valid_next = 1'b1;
                case (cmd_reg)
                    CMD_FWD, CMD_REV:
                    begin
                        if (hit_reg)
                        begin
                            wr_data.next   = nh_reg;
                            wr_data.hops   = hops_in;
                            wr_data.seq    = seq_reg;
                            wr_data.status = ST_ACTIVE;
                            if (rd.status == ST_ACTIVE)
                            begin
                                if (cmd_reg == CMD_REV && life_val <= rd.expiry)
                                    wr_data.expiry = rd.expiry;
                                else
                                    wr_data.expiry = life_val;
                                wr_en    = accept;
                                res_next = entry_result(accept ? wr_data : rd,
                                    accept && ((hops_in < rd.hops) || (rd.next != nh_reg)),
                                    accept && ((hops_in < rd.hops) || (rd.next != nh_reg)),
                                    1'b1);
                            end
                            else
                            begin
                                wr_data.expiry = life_val;
                                wr_en          = 1'b1;
                                res_next       = entry_result(wr_data, 1'b0, 1'b1, 1'b1);
                            end
                        end
                        else if (free_reg)
                        begin
                            wr_data.dest      = dest_reg;
                            wr_data.next      = nh_reg;
                            wr_data.hops      = hops_in;
                            wr_data.prev_hops = '0;
                            wr_data.seq       = seq_reg;
                            wr_data.expiry    = life_val;
                            wr_data.status    = ST_ACTIVE;
                            wr_en             = 1'b1;
                            used_next[idx_reg] = 1'b1;
                            res_next          = entry_result(wr_data, 1'b0, 1'b1, 1'b1);
                        end
                        else
                            res_next = blank_result(dest_reg, 1'b1, 1'b1);
                    end
                    CMD_NBR:
                    begin
                        wr_data.dest   = dest_reg;
                        wr_data.next   = dest_reg;
                        wr_data.hops   = NEIGHBOR_HOPS;
                        wr_data.seq    = seq_reg;
                        wr_data.expiry = life_reg;
                        wr_data.status = ST_ACTIVE;
                        if (hit_reg)
                        begin
                            wr_en    = 1'b1;
                            res_next = entry_result(wr_data, 1'b0,
                                                    rd.status != ST_ACTIVE, 1'b1);
                        end
                        else if (free_reg)
                        begin
                            wr_data.prev_hops  = '0;
                            wr_en              = 1'b1;
                            used_next[idx_reg] = 1'b1;
                            res_next           = entry_result(wr_data, 1'b0, 1'b1, 1'b1);
                        end
                        else
                            res_next = blank_result(dest_reg, 1'b1, 1'b1);
                    end
                    CMD_BREAK:
                    begin
                        total_next = (tot_raw > CNT_MAX) ? CNT_MAX : tot_raw;
                        sent_next  = CNT_W'(hit_reg);
                        if (hit_reg)
                        begin
                            // Break the neighbor's own route
                            wr_data.status = ST_BROKEN;
                            wr_data.expiry = life_val;
                            if (rd.hops == HOP_INF)
                                wr_data.hops = rd.prev_hops;
                            else
                            begin
                                wr_data.prev_hops = rd.hops;
                                wr_data.seq       = rd.seq + 32'd1;
                            end
                            wr_en    = 1'b1;
                            res_next = entry_result(wr_data, rd.hops != HOP_INF, 1'b0,
                                                    (tot_raw == CNT_W'(1)) ||
                                                    (CNT_MAX == CNT_W'(1)));
                        end
                        else if (dep_reg == '0)
                            res_next = blank_result(dest_reg, 1'b0, 1'b1);
                        else
                        begin
                            rsp_valid_next = 1'b0;
                            state_next     = S_WALK;
                            idx_next       = '0;
                        end
                    end
                    default:
                    begin
                        // Lookups
                        if (hit_reg && rd.status == ST_ACTIVE &&
                            ((cmd_reg == CMD_ACTIVE) ? (rd.expiry > now_reg)
                                                     : !seq_back[31]))
                            res_next = entry_result(rd, 1'b0, 1'b0, 1'b1);
                        else
                            res_next = blank_result(dest_reg, 1'b0, 1'b1);
                    end
                endcase
            end
            S_OUT:
            begin
                // Hold the result until the transfer
                if (rsp.ready)
                begin
                    rsp_valid_next = 1'b0;
                    if (cmd_reg == CMD_BREAK && dep_reg != '0)
                    begin
                        state_next = S_WALK;
                        idx_next   = '0;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                // Break each active route through the lost neighbor
                if (dependent)
                begin
                    wr_data.status    = ST_BROKEN;
                    wr_data.expiry    = life_val;
                    wr_data.prev_hops = rd.hops;
                    wr_data.seq       = rd.seq + 32'd1;
                    wr_en             = 1'b1;
                end
                if (dependent && sent_reg < total_reg)
                begin
                    rsp_valid_next = 1'b1;
                    res_next       = entry_result(wr_data, 1'b1, 1'b0,
                                                  sent_reg + CNT_W'(1) == total_reg);
                    sent_next      = sent_reg + CNT_W'(1);
                    state_next     = S_WOUT;
                end
                else if (idx_end)
                    state_next = S_IDLE;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_WOUT:
            begin
                if (rsp.ready)
                begin
                    rsp_valid_next = 1'b0;
                    if (idx_end)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_WALK;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            ptt_reg       <= 16'd5600;
            ntt_reg       <= 10'd40;
            art_reg       <= 16'd3000;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_PTT: ptt_reg <= pwdata[15:0];
                    REG_NTT: ntt_reg <= pwdata[9:0];
                    REG_ART: art_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        dep_reg      <= dep_next;
        sent_reg     <= sent_next;
        total_reg    <= total_next;
        term_reg     <= term_next;
        res_reg      <= res_next;
        if (state_reg == S_IDLE && req.valid)
        begin
            cmd_reg  <= req.cmd;
            dest_reg <= req.dest_addr;
            nh_reg   <= req.next_hop;
            msgh_reg <= req.msg_hop_count;
            seq_reg  <= req.seq_num;
            life_reg <= req.lifetime;
            now_reg  <= req.now;
        end
    end

    // Table write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[idx_reg] <= wr_data;
    end

    // Register read
    always_comb
    begin
        case (paddr[3:2])
            REG_PTT: prdata = {16'd0, ptt_reg};
            REG_NTT: prdata = {22'd0, ntt_reg};
            REG_ART: prdata = {16'd0, art_reg};
            default: prdata = '0;
        endcase
    end

    assign pready             = 1'b1;
    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.route_addr     = res_reg.route_addr;
    assign rsp.found          = res_reg.found;
    assign rsp.route_next_hop = res_reg.route_next_hop;
    assign rsp.route_hops     = res_reg.route_hops;
    assign rsp.route_seq      = res_reg.route_seq;
    assign rsp.kernel_del     = res_reg.kernel_del;
    assign rsp.kernel_add     = res_reg.kernel_add;
    assign rsp.table_full     = res_reg.table_full;
    assign rsp.last           = res_reg.last;
endmodule

[rtl/aodv_rt_life.sv]
// Shared lifetime adder: now + add - sub, clamped to the 32-bit range.
module aodv_rt_life (
    input  aodv_rt_pkg::life_op_t op,
    output logic [31:0]           life
);
    import aodv_rt_pkg::*;

    logic [33:0] sum;

    // Add, subtract, then clamp below at zero and above at all ones
    always_comb
    begin
        sum = {2'b00, op.now} + {2'b00, op.add} - {{(34-TERM_W){1'b0}}, op.sub};
        if (sum[33])
            life = '0;
        else if (sum[32])
            life = '1;
        else
            life = sum[31:0];
    end
endmodule

[rtl/aodv_rt_checker.sv]
// Checker: port-level assertions for the route table engine, bound to the top level.
module aodv_rt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [2:0]  req_cmd,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_last,
    input logic [31:0] rsp_route_addr
);
    import aodv_rt_pkg::*;

    // Never take a command while a result is pending
    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request ready while result pending");

    // Drop ready after taking a known command
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_cmd <= CMD_VALID) |=> !req_ready)
        else $error("ready right after accepting a command");

    // Stay busy while more results of a command follow
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !rsp_last) |=> !req_ready)
        else $error("ready before the last result");

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_route_addr)))
        else $error("stalled result changed");
endmodule

bind aodv_route_table_engine aodv_rt_checker u_aodv_rt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_last       (rsp.last),
    .rsp_route_addr (rsp.route_addr)
);

[tb/sv/tb_aodv_route_table_engine.sv]
// Testbench: directed and random command traffic against a route table predictor.
module tb_aodv_route_table_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import aodv_rt_pkg::*;

    localparam logic [2:0] CMD_NOP6 = 3'd6;
    localparam logic [2:0] CMD_NOP7 = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 100;
    localparam int POOL_N = 24;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] dest;
        logic [31:0] nh;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic [31:0] life;
        logic [31:0] now;
    } route_cmd_t;

    typedef struct packed {
        route_cmd_t it;
        logic       typed;
        result_t    res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    aodv_rt_req_if req ();
    aodv_rt_rsp_if rsp ();

    aodv_route_table_engine DUT (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow route table and registers
    logic [15:0] cfg_ptt, cfg_art;
    logic [9:0]  cfg_ntt;
    bit          rt_used [TABLE_DEPTH];
    logic [31:0] rt_dest [TABLE_DEPTH];
    logic [31:0] rt_next [TABLE_DEPTH];
    logic [7:0]  rt_hops [TABLE_DEPTH];
    logic [7:0]  rt_prev [TABLE_DEPTH];
    logic [31:0] rt_seq  [TABLE_DEPTH];
    logic [31:0] rt_exp  [TABLE_DEPTH];
    logic [1:0]  rt_st   [TABLE_DEPTH];

    result_t route_expect [$];
    int errors = 0;
    int n_items = 0, n_results = 0, n_breaks = 0, n_full = 0;
    longint cycles = 0;
    logic cur_typed = 1'b0;
    result_t cur_res = '0;
    int burst_left = 0;
    logic [31:0] pool [POOL_N];

    function automatic int find_route(logic [31:0] a);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (rt_used[i] && rt_dest[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (!rt_used[i])
                return i;
        return -1;
    endfunction

    function automatic logic [31:0] sat_sum(logic [31:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] rev_lifetime(logic [31:0] now, logic [7:0] hops);
        longint v;
        v = longint'(now) + longint'(cfg_ptt) - 2 * longint'(hops) * longint'(cfg_ntt);
        if (v < 0)
            return 32'd0;
        if (v > 64'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic result_t blank_res(logic [31:0] a, logic full);
        result_t r;
        r = '0;
        r.route_addr = a;
        r.table_full = full;
        return r;
    endfunction

    function automatic result_t entry_res(int i, logic kdel, logic kadd);
        result_t r;
        r = '0;
        r.route_addr = rt_dest[i];
        r.found = 1'b1;
        r.route_next_hop = rt_next[i];
        r.route_hops = rt_hops[i];
        r.route_seq = rt_seq[i];
        r.kernel_del = kdel;
        r.kernel_add = kadd;
        return r;
    endfunction

    // Apply one command to the shadow table and return the results it causes
    task automatic predict_route(input route_cmd_t c, output result_t rq [$]);
        int i, own;
        logic kdel, kadd;
        logic [7:0] hops;
        logic [31:0] diff, lt;
        logic rev;
        rq = {};
        kdel = 0;
        kadd = 0;
        rev = (c.cmd == CMD_REV);
        hops = (c.hops == 8'hFF) ? HOP_INF : c.hops + 8'd1;
        case (c.cmd)
            CMD_FWD, CMD_REV:
            begin
                i = find_route(c.dest);
                if (i >= 0 && rt_st[i] == ST_ACTIVE)
                begin
                    diff = c.seq - rt_seq[i];
                    if ((diff != 0 && diff < 32'h8000_0000) || (diff == 0 && hops < rt_hops[i]))
                    begin
                        if (hops < rt_hops[i] || rt_next[i] != c.nh)
                        begin
                            kdel = 1;
                            kadd = 1;
                        end
                        rt_next[i] = c.nh;
                        rt_hops[i] = hops;
                        rt_seq[i] = c.seq;
                        if (rev)
                        begin
                            lt = rev_lifetime(c.now, hops);
                            if (lt > rt_exp[i])
                                rt_exp[i] = lt;
                        end
                        else
                            rt_exp[i] = sat_sum(c.now, c.life);
                    end
                    rq.push_back(entry_res(i, kdel, kadd));
                end
                else
                begin
                    if (i < 0)
                    begin
                        i = free_slot();
                        if (i >= 0)
                        begin
                            rt_used[i] = 1;
                            rt_dest[i] = c.dest;
                            rt_prev[i] = 8'd0;
                        end
                    end
                    if (i < 0)
                        rq.push_back(blank_res(c.dest, 1'b1));
                    else
                    begin
                        rt_next[i] = c.nh;
                        rt_hops[i] = hops;
                        rt_seq[i] = c.seq;
                        rt_st[i] = ST_ACTIVE;
                        rt_exp[i] = rev ? rev_lifetime(c.now, hops) : sat_sum(c.now, c.life);
                        rq.push_back(entry_res(i, 1'b0, 1'b1));
                    end
                end
            end
            CMD_NBR:
            begin
                i = find_route(c.dest);
                if (i < 0)
                begin
                    i = free_slot();
                    if (i >= 0)
                    begin
                        rt_used[i] = 1;
                        rt_dest[i] = c.dest;
                        rt_prev[i] = 8'd0;
                        rt_st[i] = 2'd0;
                    end
                end
                if (i < 0)
                    rq.push_back(blank_res(c.dest, 1'b1));
                else
                begin
                    rt_next[i] = c.dest;
                    rt_exp[i] = c.life;
                    rt_hops[i] = NEIGHBOR_HOPS;
                    rt_seq[i] = c.seq;
                    kadd = (rt_st[i] != ST_ACTIVE);
                    rt_st[i] = ST_ACTIVE;
                    rq.push_back(entry_res(i, 1'b0, kadd));
                end
            end
            CMD_BREAK:
            begin
                own = find_route(c.dest);
                if (own >= 0)
                begin
                    rt_st[own] = ST_BROKEN;
                    rt_exp[own] = sat_sum(c.now, longint'(BREAK_FACTOR) * cfg_art);
                    if (rt_hops[own] == HOP_INF)
                        rt_hops[own] = rt_prev[own];
                    else
                    begin
                        rt_prev[own] = rt_hops[own];
                        rt_seq[own] = rt_seq[own] + 32'd1;
                        kdel = 1;
                    end
                    rq.push_back(entry_res(own, kdel, 1'b0));
                end
                for (int k = 0; k < TABLE_DEPTH; k++)
                begin
                    if (k == own || !rt_used[k] || rt_next[k] != c.dest || rt_st[k] != ST_ACTIVE)
                        continue;
                    rt_st[k] = ST_BROKEN;
                    rt_exp[k] = sat_sum(c.now, cfg_art);
                    rt_prev[k] = rt_hops[k];
                    rt_seq[k] = rt_seq[k] + 32'd1;
                    if (rq.size() < MAX_RESULTS)
                        rq.push_back(entry_res(k, 1'b1, 1'b0));
                end
                if (rq.size() == 0)
                    rq.push_back(blank_res(c.dest, 1'b0));
            end
            CMD_ACTIVE, CMD_VALID:
            begin
                i = find_route(c.dest);
                if (i >= 0 && rt_st[i] == ST_ACTIVE &&
                    (c.cmd == CMD_ACTIVE ? rt_exp[i] > c.now
                                         : (rt_seq[i] - c.seq) < 32'h8000_0000))
                    rq.push_back(entry_res(i, 1'b0, 1'b0));
                else
                    rq.push_back(blank_res(c.dest, 1'b0));
            end
            default: ;
        endcase
        if (rq.size() > 0)
            rq[rq.size() - 1].last = 1'b1;
    endtask

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, e, a);
            errors++;
        end
    endfunction

    // Record accepted commands and check result transfers
    always @(posedge clk)
    begin
        result_t e, act;
        result_t rq [$];
        route_cmd_t c;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            act = '{rsp.route_addr, rsp.found, rsp.route_next_hop, rsp.route_hops,
                    rsp.route_seq, rsp.kernel_del, rsp.kernel_add, rsp.table_full, rsp.last};
            n_results++;
            if (act.table_full)
                n_full++;
            if (route_expect.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, act);
                errors++;
            end
            else
            begin
                e = route_expect.pop_front();
                check_field("route_addr", e.route_addr, act.route_addr);
                check_field("found", e.found, act.found);
                check_field("route_next_hop", e.route_next_hop, act.route_next_hop);
                check_field("route_hops", e.route_hops, act.route_hops);
                check_field("route_seq", e.route_seq, act.route_seq);
                check_field("kernel_del", e.kernel_del, act.kernel_del);
                check_field("kernel_add", e.kernel_add, act.kernel_add);
                check_field("table_full", e.table_full, act.table_full);
                check_field("last", e.last, act.last);
            end
        end
        if (rst_n && req.valid && req.ready)
        begin
            c = '{req.cmd, req.dest_addr, req.next_hop, req.msg_hop_count, req.seq_num,
                  req.lifetime, req.now};
            n_items++;
            if (c.cmd == CMD_BREAK)
                n_breaks++;
            predict_route(c, rq);
            if (cur_typed)
                route_expect.push_back(cur_res);
            else
                foreach (rq[k])
                    route_expect.push_back(rq[k]);
        end
    end

    // Receiver stall pattern: four ready modes taken in turn
    always @(posedge clk)
    begin
        int mode;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        mode = int'((cycles / 64) % 4);
        case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 1) == 1);
            2: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= (cycles % 8 == 0);
        endcase
    end

    task automatic send_cmd(input route_cmd_t c, input logic typed, input result_t r);
        if (burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(1, 8);
        end
        req.valid <= 1'b1;
        req.cmd <= c.cmd;
        req.dest_addr <= c.dest;
        req.next_hop <= c.nh;
        req.msg_hop_count <= c.hops;
        req.seq_num <= c.seq;
        req.lifetime <= c.life;
        req.now <= c.now;
        cur_typed <= typed;
        cur_res <= r;
        do
            @(posedge clk);
        while (!req.ready);
        burst_left--;
    endtask

    // Hold the sender until every expected result has arrived and the block settles
    task automatic drain();
        req.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (route_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
        logic [31:0] mask;
        mask = (idx == REG_NTT) ? 32'h3FF : 32'hFFFF;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << 2; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== (v & mask))
        begin
            $display("%0t: register %0d readback expected %h, actual %h",
                     $time, idx, v & mask, prdata);
            errors++;
        end
        psel <= 1'b0; penable <= 1'b0;
        case (idx)
            REG_PTT: cfg_ptt = v[15:0];
            REG_NTT: cfg_ntt = v[9:0];
            default: cfg_art = v[15:0];
        endcase
    endtask

    function automatic route_cmd_t rand_cmd();
        route_cmd_t c;
        int w;
        w = $urandom_range(0, 99);
        if (w < 25)      c.cmd = CMD_FWD;
        else if (w < 45) c.cmd = CMD_REV;
        else if (w < 60) c.cmd = CMD_NBR;
        else if (w < 70) c.cmd = CMD_BREAK;
        else if (w < 82) c.cmd = CMD_ACTIVE;
        else if (w < 95) c.cmd = CMD_VALID;
        else             c.cmd = $urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7;
        c.dest = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_N - 1)];
        c.nh = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 3)];
        c.hops = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(200, 254))
                                             : 8'($urandom_range(0, 6));
        c.seq = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6);
        c.life = $urandom;
        c.now = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000);
        return c;
    endfunction

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
            send_cmd(rand_cmd(), 1'b0, '0);
    endtask

    function automatic dir_row_t row(logic [2:0] cmd, logic [31:0] d, logic [31:0] nh,
                                     logic [7:0] h, logic [31:0] s, logic [31:0] l,
                                     logic [31:0] n);
        dir_row_t r;
        r.it = '{cmd, d, nh, h, s, l, n};
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic dir_row_t miss_row(logic [2:0] cmd, logic [31:0] d);
        dir_row_t r;
        r = row(cmd, d, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0);
        r.typed = 1'b1;
        r.res = blank_res(d, 1'b0);
        r.res.last = 1'b1;
        return r;
    endfunction

    initial
    begin
        dir_row_t dir [$];
        route_cmd_t c;
        req.valid = 1'b0; req.cmd = '0; req.dest_addr = '0; req.next_hop = '0;
        req.msg_hop_count = '0; req.seq_num = '0; req.lifetime = '0; req.now = '0;
        rsp.ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_ptt = 16'd5600; cfg_ntt = 10'd40; cfg_art = 16'd3000;
        foreach (rt_used[i])
            rt_used[i] = 0;
        foreach (pool[i])
            pool[i] = $urandom;
        pool[0] = 32'hFFFF_FFFF;
        pool[1] = 32'h0000_0000;

        // Empty table: misses, a break with nothing to break and the dropped codes 6 and 7
        dir.push_back(miss_row(CMD_ACTIVE, 32'h0000_0000));
        dir.push_back(miss_row(CMD_VALID, 32'hFFFF_FFFF));
        dir.push_back(miss_row(CMD_BREAK, 32'h1234_5678));
        dir.push_back(row(CMD_NOP6, 32'hFFFF_FFFF, '1, 8'hFF, '1, '1, '1));
        dir.push_back(row(CMD_NOP7, 32'h0, 32'h0, 8'h0, 32'h0, 32'h0, 32'h0));
        // A neighbor, then routes through it and other hops; lifetime saturates
        dir.push_back(row(CMD_NBR, 32'hFFFF_FFFF, 32'h0, 8'd0, 32'd7, 32'h0000_1000, 32'd0));
        dir.push_back(row(CMD_FWD, 32'hA000_0001, 32'hFFFF_FFFF, 8'd0, 32'd0, '1, '1));
        dir.push_back(row(CMD_FWD, 32'hA000_0001, 32'hFFFF_FFFF, 8'd3, 32'd0, 32'd5, 32'd9));
        dir.push_back(row(CMD_FWD, 32'hA000_0001, 32'h0, 8'd5, 32'h8000_0000, 32'd5, 32'd9));
        dir.push_back(row(CMD_FWD, 32'hA000_0001, 32'h0, 8'd5, 32'd1, 32'd100, 32'd9));
        dir.push_back(row(CMD_FWD, 32'hA000_0001, 32'hFFFF_FFFF, 8'd2, 32'd1, 32'd100, 32'd9));
        // Reverse lifetimes clamp at both ends; hop count saturates
        dir.push_back(row(CMD_REV, 32'hB000_0002, 32'hFFFF_FFFF, 8'd254, 32'd3, 32'd0, 32'd0));
        dir.push_back(row(CMD_REV, 32'hB000_0003, 32'h0, 8'd0, '1, 32'd0, '1));
        dir.push_back(row(CMD_REV, 32'hB000_0003, 32'h0, 8'd0, 32'd0, 32'd0, 32'd500));
        dir.push_back(row(CMD_ACTIVE, 32'hA000_0001, 32'h0, 8'd0, 32'd0, 32'd0, 32'd108));
        dir.push_back(row(CMD_ACTIVE, 32'hA000_0001, 32'h0, 8'd0, 32'd0, 32'd0, 32'd109));
        dir.push_back(row(CMD_VALID, 32'hA000_0001, 32'h0, 8'd0, 32'd2, 32'd0, 32'd0));
        dir.push_back(row(CMD_VALID, 32'hA000_0001, 32'h0, 8'd0, 32'h8000_0001, 32'd0, 32'd0));
        // Break the neighbor: own entry plus dependents; infinite-hop entry
        dir.push_back(row(CMD_BREAK, 32'hFFFF_FFFF, 32'h0, 8'd0, 32'd0, 32'd0, 32'd50));
        dir.push_back(row(CMD_BREAK, 32'hB000_0002, 32'h0, 8'd0, 32'd0, 32'd0, '1));
        dir.push_back(row(CMD_BREAK, 32'hB000_0002, 32'h0, 8'd0, 32'd0, 32'd0, 32'd1));
        // Overwrite broken entries
        dir.push_back(row(CMD_FWD, 32'hA000_0001, 32'h5555_AAAA, 8'd9, 32'd0, 32'd0, 32'd0));
        dir.push_back(row(CMD_NBR, 32'hFFFF_FFFF, 32'h0, 8'd0, 32'd0, '1, 32'd0));
        dir.push_back(row(CMD_VALID, 32'hB000_0002, 32'h0, 8'd0, 32'd0, 32'd0, 32'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[k])
            send_cmd(dir[k].it, dir[k].typed, dir[k].res);
        random_phase(15);
        drain();

        // Extreme register settings
        apb_write(REG_PTT, 32'h0);
        apb_write(REG_NTT, 32'h3FF);
        apb_write(REG_ART, 32'hFFFF);
        random_phase(20);
        drain();
        apb_write(REG_PTT, 32'hFFFF);
        apb_write(REG_NTT, 32'h0);
        apb_write(REG_ART, 32'h0);
        random_phase(15);
        drain();
        random_phase(15);
        drain();
        apb_write(REG_PTT, $urandom);
        apb_write(REG_NTT, $urandom);
        apb_write(REG_ART, $urandom);
        random_phase(25);

        // Fill the table through one neighbor, then break it for a long run of results
        for (int k = 0; k < 36; k++)
        begin
            c = rand_cmd();
            c.cmd = $urandom_range(0, 1) ? CMD_FWD : CMD_REV;
            c.dest = $urandom;
            c.nh = pool[1];
            send_cmd(c, 1'b0, '0);
        end
        c = rand_cmd();
        c.cmd = CMD_BREAK;
        c.dest = pool[1];
        send_cmd(c, 1'b0, '0);
        random_phase(10);
        drain();

        $display("Covered %0d commands (%0d link breaks), %0d results, %0d full-table drops,",
                 n_items, n_breaks, n_results, n_full);
        $display("over four register settings with sender gaps and receiver stalls.");
        if (errors == 0 && route_expect.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
